>>> sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the interrupt slot translation block.
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam int ADDR_W   = 41;
   localparam int TGT_W    = 7;
   localparam int HWID_W   = 7;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // hardware id field of the interrupt-map address
   localparam int HWID_LSB = 33;
   localparam int HWID_MSB = 39;

   // translation register address = base + (id << 33) + offset + slot * 16
   localparam logic [ADDR_W-1:0] XLAT_REG_BASE = 41'h100fc000000;
   localparam logic [ADDR_W-1:0] TREG_OFFSET   = 41'h200;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_UNKNOWN_ID = 2'd1,
      STATUS_FULL       = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESENT_LOW  = 1'b0,
      CSR_PRESENT_HIGH = 1'b1
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic take;         // capture accepted item
      logic cnt_read;     // read fill count of the id
      logic cnt_latch;    // latch fill count, restart scan
      logic issue;        // read next slot address
      logic res_unknown;  // finish with unknown id
      logic res_full;     // finish with all slots full
      logic res_hit;      // finish on matching slot
      logic res_claim;    // finish by claiming first free slot
      logic out_load;     // move result into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic id_bad;
      logic hit;
      logic more;
      logic pend;
      logic full;
      logic out_free;
   } stat_type;

endpackage

>>> sv/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer: accepts an item, checks the id, walks the slots, hands off result.
// ----------------------------------------------------------------------------
module ist_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ist_pkg::stat_type st,
   output ist_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_COUNT = 5'b00100,
      S_SCAN  = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.id_bad) begin
               cmd.res_unknown = 1'b1;
               state_in        = S_FIN;
            end else begin
               cmd.cnt_read = 1'b1;
               state_in     = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.cnt_latch = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (st.hit) begin
               cmd.res_hit = 1'b1;
               state_in    = S_FIN;
            end else if (st.more) begin
               cmd.issue = 1'b1;
            end else if (!st.pend) begin
               // every used slot compared without a match
               if (st.full) begin
                  cmd.res_full = 1'b1;
               end else begin
                  cmd.res_claim = 1'b1;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_scan_ends_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_hit || cmd.res_claim || cmd.res_full || cmd.res_unknown) |=> !req_tready)
      else $error("item finished without passing through result hand-off");
`endif

endmodule

>>> sv/ist_dpath.sv
// ----------------------------------------------------------------------------
// ist_dpath
// Datapath: presence bitmap, per-id fill counts, slot address memory, result.
// ----------------------------------------------------------------------------
module ist_dpath #(
   parameter int SLOTS_PER_ID = 32,
   parameter int ID_COUNT     = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [ist_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ist_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [ist_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  ist_pkg::cmd_type                     cmd,
   output ist_pkg::stat_type                    st,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ist_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int CNT_W     = $clog2(SLOTS_PER_ID + 1);
   localparam int ID_AW     = $clog2(ID_COUNT);
   localparam int MEM_DEPTH = ID_COUNT * SLOTS_PER_ID;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam int AW = ist_pkg::ADDR_W;

   // configuration
   logic [ist_pkg::CSR_W-1:0] present_low_ff, present_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_low_ff  <= '0;
         present_high_ff <= '0;
      end else if (csr_wen) begin
         unique case (ist_pkg::csr_index_type'(csr_index))
            ist_pkg::CSR_PRESENT_LOW:  present_low_ff  <= csr_wdata;
            ist_pkg::CSR_PRESENT_HIGH: present_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item registers
   logic [AW-1:0]                   addr_ff, addr_in;
   logic [ist_pkg::TGT_W-1:0]       target_ff, target_in;
   logic [ist_pkg::HWID_W-1:0]      hwid;
   logic [ID_AW-1:0]                id_idx;
   logic [2*ist_pkg::CSR_W-1:0]     present_bits;
   logic                            id_in_range;
   logic [MEM_AW-1:0]               base_ff, base_in;

   always_comb begin
      addr_in   = addr_ff;
      target_in = target_ff;
      if (cmd.take) begin
         addr_in   = req_tdata[AW-1:0];
         target_in = req_tdata[AW +: ist_pkg::TGT_W];
      end
   end

   assign hwid         = addr_ff[ist_pkg::HWID_MSB:ist_pkg::HWID_LSB];
   assign id_idx       = hwid[ID_AW-1:0];
   assign present_bits = {present_high_ff, present_low_ff};
   assign id_in_range  = {1'b0, hwid} < 8'(ID_COUNT);
   assign base_in      = cmd.cnt_read ? MEM_AW'(id_idx * SLOTS_PER_ID) : base_ff;

   // per-id fill count: slots are claimed in order, so used slots form a prefix
   logic [CNT_W-1:0] fill_mem [ID_COUNT];
   logic [ID_COUNT-1:0] fill_vld_ff;
   logic [CNT_W-1:0] fill_rd_ff;
   logic             fill_rd_vld_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   // scan state
   logic [AW-1:0]     slot_addr_mem [MEM_DEPTH];
   logic [AW-1:0]     slot_rd_ff;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              pend_ff, pend_in;
   logic [MEM_AW-1:0] slot_ptr;

   assign slot_ptr = base_ff + MEM_AW'(scan_idx_ff);

   always_comb begin
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = cmd.issue;
      if (cmd.cnt_latch) begin
         count_in    = fill_rd_vld_ff ? fill_rd_ff : '0;
         scan_idx_in = '0;
      end
      if (cmd.issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
         pend_idx_in = scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_read) begin
         fill_rd_ff <= fill_mem[id_idx];
      end
      if (cmd.res_claim) begin
         fill_mem[id_idx] <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         slot_rd_ff <= slot_addr_mem[slot_ptr];
      end
      if (cmd.res_claim) begin
         slot_addr_mem[slot_ptr] <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (cmd.res_claim) begin
         fill_vld_ff[id_idx] <= 1'b1;
      end
   end

   // result registers
   ist_pkg::status_type res_status_ff, res_status_in;
   logic [CNT_W-1:0]    res_slot_ff, res_slot_in;

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      if (cmd.res_unknown) begin
         res_status_in = ist_pkg::STATUS_UNKNOWN_ID;
      end else if (cmd.res_full) begin
         res_status_in = ist_pkg::STATUS_FULL;
      end else if (cmd.res_hit) begin
         res_status_in = ist_pkg::STATUS_OK;
         res_slot_in   = pend_idx_ff;
      end else if (cmd.res_claim) begin
         res_status_in = ist_pkg::STATUS_OK;
         res_slot_in   = scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      target_ff      <= target_in;
      base_ff        <= base_in;
      count_ff       <= count_in;
      scan_idx_ff    <= scan_idx_in;
      pend_idx_ff    <= pend_idx_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      if (cmd.cnt_read) begin
         fill_rd_vld_ff <= fill_vld_ff[id_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ist_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [6:0]                    slot_wide;
   logic [AW-1:0]                 treg_addr;
   logic                          res_ok;

   assign slot_wide = 7'(res_slot_ff);
   assign res_ok    = res_status_ff == ist_pkg::STATUS_OK;
   assign treg_addr = ist_pkg::XLAT_REG_BASE + {1'b0, hwid, 33'b0} + ist_pkg::TREG_OFFSET
                    + {30'b0, slot_wide, 4'b0};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (res_ok) begin
            rsp_data_in = {1'b0, target_ff, treg_addr, slot_wide[4:0], res_status_ff};
         end else begin
            rsp_data_in = {1'b0, 7'b0, 41'b0, 5'b0, res_status_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status to controller
   assign st.id_bad   = !id_in_range || !present_bits[hwid];
   assign st.hit      = pend_ff && (slot_rd_ff == addr_ff);
   assign st.more     = scan_idx_ff < count_ff;
   assign st.pend     = pend_ff;
   assign st.full     = count_ff == CNT_W'(SLOTS_PER_ID);
   assign st.out_free = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote an item not yet taken");
   a_claim_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.res_claim |-> (!pend_ff && scan_idx_ff == count_ff && count_ff < CNT_W'(SLOTS_PER_ID)))
      else $error("slot claimed before all used slots were compared");
   a_hit_from_read: assert property (@(posedge clock) disable iff (reset)
      cmd.res_hit |-> ($past(cmd.issue) && pend_idx_ff < count_ff))
      else $error("match reported without a slot read in flight");
`endif

endmodule

>>> sv/interrupt_slot_translate_top.sv
// ----------------------------------------------------------------------------
// interrupt_slot_translate_top
// Maps an interrupt-map address to a translation slot of its hardware id.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per request, an interrupt-map address and a target
//   processor id. rsp channel: one item per request with status, slot, the
//   translation register address and the data written to it.
//   csr port: write index 0/1 to load the present-id bitmap (ids 0-63/64-127)
//   while the block is idle; writes take effect at once.
// Timing:
//   An unknown id is answered from the id check, without any slot read. A
//   present id first reads its fill count n, the slots already used by that
//   id (at most SLOTS_PER_ID), then reads one slot address per cycle, until a
//   match, from the single-port slot memory, each compared in the cycle after its read.
//   One item is processed at a time; the next is accepted once the result
//   sits in the output register, even if the receiver has not taken it.
// Reset: bitmap cleared, all slots free; no clearing pass is needed since the
//   per-id fill counts are qualified by valid bits cleared at reset.
// Stall: the result waits in the output register while rsp_tready is low;
//   a following result waits inside the block until that one is taken.
// ----------------------------------------------------------------------------
module interrupt_slot_translate_top #(
   parameter int SLOTS_PER_ID = 32,
   parameter int ID_COUNT     = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [ist_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ist_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [40:0] imap_addr, [47:41] target_id
   input  logic [ist_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] status, [6:2] slot, [47:7] treg_addr, [54:48] treg_data, [55] zero
   output logic [ist_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   ist_pkg::cmd_type  cmd;
   ist_pkg::stat_type st;

   ist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   ist_dpath #(
      .SLOTS_PER_ID (SLOTS_PER_ID),
      .ID_COUNT     (ID_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in progress");
`endif

endmodule
